// ===== src/idkp_pkg.sv =====
package idkp_pkg;

  localparam int BYTE_W = 8;
  localparam int VALUE_W = 64;
  localparam int OFFSET_W = 13;
  localparam int STATUS_W = 3;
  localparam int DIGIT_W = 4;
  localparam int DEFAULT_MAX_LENGTH = 4096;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'd7;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;
  localparam logic [BYTE_W-1:0] PLUS_BYTE = 8'd43;
  localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'd45;

  typedef enum logic [2:0] {
    CLS_MARKER,
    CLS_SPACE,
    CLS_HIGH,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SKIP,
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EMPTY,
    ST_NAME,
    ST_SHORT,
    ST_LOCALE,
    ST_NODIGIT,
    ST_RANGE,
    ST_ID
  } status_t;

  // One classified word, as it travels from the front to the back.
  typedef struct packed {
    logic                used;     // byte counts: before the first NUL
    logic                last;
    cls_t                cls;
    logic [DIGIT_W-1:0]  digit;
    logic [OFFSET_W-1:0] end_pos;  // saturated offset just past this byte
  } tok_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

endpackage

// ===== src/idkp_byte_if.sv =====
interface idkp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [idkp_pkg::BYTE_W-1:0]  byte_in;
  logic                         last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

// ===== src/idkp_result_if.sv =====
interface idkp_result_if;
  logic                           valid;
  logic                           ready;
  logic [idkp_pkg::STATUS_W-1:0]  key_status;
  logic [idkp_pkg::VALUE_W-1:0]   id_value;
  logic [idkp_pkg::OFFSET_W-1:0]  end_offset;

  modport source (output valid, output key_status, output id_value, output end_offset,
                  input ready);
  modport sink (input valid, input key_status, input id_value, input end_offset,
                output ready);
endinterface

// ===== src/idkp_front.sv =====
module idkp_front #(
  parameter int MAX_LENGTH = idkp_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic               clk,
  input  logic               rst,
  idkp_byte_if.sink          stream,
  input  idkp_pkg::q_sts_t   q_sts,
  output logic               push,
  output idkp_pkg::tok_t     tok
);

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);
  localparam logic [POS_W-1:0] NEAR_MAX = POS_W'(MAX_LENGTH - 1);

  logic             nul_seen;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] end_full;
  logic             take;

  assign stream.ready = !q_sts.full;
  assign take = stream.valid && stream.ready;
  assign push = take;

  always_comb begin
    tok.cls = idkp_pkg::CLS_OTHER;
    if (stream.byte_in == idkp_pkg::MARKER_BYTE) begin
      tok.cls = idkp_pkg::CLS_MARKER;
    end else if (stream.byte_in == idkp_pkg::SPACE_BYTE || stream.byte_in inside {[9:13]}) begin
      tok.cls = idkp_pkg::CLS_SPACE;
    end else if (stream.byte_in[idkp_pkg::BYTE_W-1]) begin
      tok.cls = idkp_pkg::CLS_HIGH;
    end else if (stream.byte_in == idkp_pkg::PLUS_BYTE) begin
      tok.cls = idkp_pkg::CLS_PLUS;
    end else if (stream.byte_in == idkp_pkg::MINUS_BYTE) begin
      tok.cls = idkp_pkg::CLS_MINUS;
    end else if (stream.byte_in inside {[48:57]}) begin
      tok.cls = idkp_pkg::CLS_DIGIT;
    end
    end_full = (pos >= NEAR_MAX) ? MAX_POS : pos + POS_W'(1);
    tok.digit = stream.byte_in[idkp_pkg::DIGIT_W-1:0];
    tok.end_pos = idkp_pkg::OFFSET_W'(end_full);
    tok.used = !nul_seen && (stream.byte_in != '0);
    tok.last = stream.last_byte;
  end

  // Track the first NUL and the saturating byte position; clear on the last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      nul_seen <= 1'b0;
      pos <= '0;
    end else if (take) begin
      if (stream.last_byte) begin
        nul_seen <= 1'b0;
        pos <= '0;
      end else if (!nul_seen) begin
        if (stream.byte_in == '0) begin
          nul_seen <= 1'b1;
        end else if (pos < MAX_POS) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/idkp_queue.sv =====
module idkp_queue (
  input  logic               clk,
  input  logic               rst,
  input  idkp_pkg::q_ctl_t   q_ctl,
  input  idkp_pkg::tok_t     wr_tok,
  output idkp_pkg::q_sts_t   q_sts,
  output idkp_pkg::tok_t     rd_tok
);

  localparam int PTR_W = (idkp_pkg::QUEUE_DEPTH > 1) ? $clog2(idkp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(idkp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(idkp_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(idkp_pkg::QUEUE_DEPTH);

  idkp_pkg::tok_t   slots [idkp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_sts.full = (count == DEPTH_CNT);
  assign q_sts.empty = (count == '0);
  assign rd_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (q_ctl.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_ctl.pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (q_ctl.push && !q_ctl.pop) begin
        count <= count + CNT_W'(1);
      end else if (q_ctl.pop && !q_ctl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/idkp_back.sv =====
module idkp_back (
  input  logic               clk,
  input  logic               rst,
  input  idkp_pkg::tok_t     tok,
  input  idkp_pkg::q_sts_t   q_sts,
  output logic               pop,
  idkp_result_if.source      result
);

  localparam int VW = idkp_pkg::VALUE_W;

  idkp_pkg::phase_t            phase, phase_next;
  logic [VW-1:0]               acc, acc_next;
  logic [VW-1:0]               nacc, nacc_next;
  logic                        ovf, ovf_next;
  logic                        neg, neg_next;
  idkp_pkg::status_t           outcome, outcome_next;
  logic [idkp_pkg::OFFSET_W-1:0] dend, dend_next;

  logic [VW+3:0]               prod;
  logic [VW-1:0]               nprod;
  logic                        ovf_hit;
  logic                        do_take;
  idkp_pkg::status_t           status;
  logic [VW-1:0]               value;
  logic [idkp_pkg::OFFSET_W-1:0] offset;

  logic                        res_valid;
  idkp_pkg::status_t           res_status;
  logic [VW-1:0]               res_value;
  logic [idkp_pkg::OFFSET_W-1:0] res_offset;

  // Hold a last word at the head while the previous result waits; advance all others.
  assign pop = !q_sts.empty && (!tok.last || !res_valid || result.ready);

  assign result.valid = res_valid;
  assign result.key_status = res_status;
  assign result.id_value = res_value;
  assign result.end_offset = res_offset;

  always_comb begin
    // Multiply by ten as two shifts; carry out of 64 bits means overflow.
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VW+4)'(tok.digit);
    nprod = (nacc << 3) + (nacc << 1) - VW'(tok.digit);
    ovf_hit = (prod[VW+3:VW] != 4'b0);

    phase_next = phase;
    acc_next = acc;
    nacc_next = nacc;
    ovf_next = ovf;
    neg_next = neg;
    outcome_next = outcome;
    dend_next = dend;
    do_take = 1'b0;

    if (tok.used) begin
      case (phase)
        idkp_pkg::PH_FIRST: begin
          if (tok.cls != idkp_pkg::CLS_MARKER) begin
            outcome_next = idkp_pkg::ST_NAME;
            phase_next = idkp_pkg::PH_DONE;
          end else begin
            phase_next = idkp_pkg::PH_SKIP;
          end
        end
        idkp_pkg::PH_SKIP: begin
          phase_next = idkp_pkg::PH_SPACE;
        end
        idkp_pkg::PH_SPACE: begin
          case (tok.cls)
            idkp_pkg::CLS_SPACE: begin
            end
            idkp_pkg::CLS_HIGH: begin
              outcome_next = idkp_pkg::ST_LOCALE;
              phase_next = idkp_pkg::PH_DONE;
            end
            idkp_pkg::CLS_PLUS, idkp_pkg::CLS_MINUS: begin
              neg_next = (tok.cls == idkp_pkg::CLS_MINUS);
              phase_next = idkp_pkg::PH_SIGNED;
            end
            idkp_pkg::CLS_DIGIT: begin
              do_take = 1'b1;
            end
            default: begin
              outcome_next = idkp_pkg::ST_NODIGIT;
              phase_next = idkp_pkg::PH_DONE;
            end
          endcase
        end
        idkp_pkg::PH_SIGNED: begin
          if (tok.cls == idkp_pkg::CLS_DIGIT) begin
            do_take = 1'b1;
          end else begin
            outcome_next = idkp_pkg::ST_NODIGIT;
            phase_next = idkp_pkg::PH_DONE;
          end
        end
        idkp_pkg::PH_DIGITS: begin
          if (tok.cls == idkp_pkg::CLS_DIGIT) begin
            do_take = 1'b1;
          end else begin
            outcome_next = ovf ? idkp_pkg::ST_RANGE : idkp_pkg::ST_ID;
            phase_next = idkp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    // Advance the value and its negation side by side; hold both once overflowed.
    if (do_take) begin
      if (ovf_hit) begin
        ovf_next = 1'b1;
      end else if (!ovf) begin
        acc_next = prod[VW-1:0];
        nacc_next = nprod;
      end
      dend_next = tok.end_pos;
      phase_next = idkp_pkg::PH_DIGITS;
    end

    case (phase_next)
      idkp_pkg::PH_FIRST:  status = idkp_pkg::ST_EMPTY;
      idkp_pkg::PH_SKIP:   status = idkp_pkg::ST_SHORT;
      idkp_pkg::PH_SPACE:  status = idkp_pkg::ST_NODIGIT;
      idkp_pkg::PH_SIGNED: status = idkp_pkg::ST_NODIGIT;
      idkp_pkg::PH_DIGITS: status = ovf_next ? idkp_pkg::ST_RANGE : idkp_pkg::ST_ID;
      default:             status = outcome_next;
    endcase

    value = '0;
    offset = '0;
    if (status == idkp_pkg::ST_ID) begin
      value = neg_next ? nacc_next : acc_next;
      offset = dend_next;
    end

    // Drop all parse state after the last word.
    if (tok.last) begin
      phase_next = idkp_pkg::PH_FIRST;
      acc_next = '0;
      nacc_next = '0;
      ovf_next = 1'b0;
      neg_next = 1'b0;
      outcome_next = idkp_pkg::ST_EMPTY;
      dend_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= idkp_pkg::PH_FIRST;
      acc <= '0;
      nacc <= '0;
      ovf <= 1'b0;
      neg <= 1'b0;
      outcome <= idkp_pkg::ST_EMPTY;
      dend <= '0;
    end else if (pop) begin
      phase <= phase_next;
      acc <= acc_next;
      nacc <= nacc_next;
      ovf <= ovf_next;
      neg <= neg_next;
      outcome <= outcome_next;
      dend <= dend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && tok.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      res_status <= status;
      res_value <= value;
      res_offset <= offset;
    end
  end

endmodule

// ===== src/identifier_decimal_key_parser.sv =====
// Identifier decimal key parser: takes an identifier one byte word per clock and, on the
// word flagged last, returns one result word with a status (empty, name key, too short,
// locale byte, no digits, out of range, numeric id), the 64-bit value (two's complement
// when a minus sign leads) and the offset just past the last digit, saturating at
// MAX_LENGTH and kept to 13 bits. A byte is accepted every clock; the front classifies
// it and the back folds it into the parse state, with a two-word queue between them.
// The result word is registered: the last byte is written into the queue, and when it
// reaches the head the back folds it in and loads the output register, unless an untaken
// result holds it there. The output register lets the next identifier stream in while
// a result waits to be taken; the input stalls only when a last byte is held at the head
// of the queue behind an untaken result and the queue has filled behind it.
module identifier_decimal_key_parser #(
  parameter int MAX_LENGTH = idkp_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic           clk,
  input  logic           rst,
  idkp_byte_if.sink      stream,
  idkp_result_if.source  result
);

  idkp_pkg::q_ctl_t q_ctl;
  idkp_pkg::q_sts_t q_sts;
  idkp_pkg::tok_t   front_tok;
  idkp_pkg::tok_t   head_tok;
  logic             push;
  logic             pop;

  assign q_ctl.push = push;
  assign q_ctl.pop = pop;

  // Front: classify each byte, mark bytes from the first NUL as unused, and
  // attach the saturated end offset.
  idkp_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .q_sts  (q_sts),
    .push   (push),
    .tok    (front_tok)
  );

  // Queue: decouple the byte side from the result side.
  idkp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_ctl  (q_ctl),
    .wr_tok (front_tok),
    .q_sts  (q_sts),
    .rd_tok (head_tok)
  );

  // Back: run the parse state machine, accumulate digits and register the result.
  idkp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .tok    (head_tok),
    .q_sts  (q_sts),
    .pop    (pop),
    .result (result)
  );

endmodule
